@@ hdl/apl_pkg.sv @@
package apl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 7;
  localparam int VOL_W    = 7;
  localparam int PROD_W   = 22;   // |sample| * volume, at most 3276800
  localparam int RECIP_W  = 23;
  localparam int WIDE_W   = PROD_W + RECIP_W;
  localparam int SUM_W    = 10;   // old*7 + new, at most 800

  typedef logic [SAMPLE_W-1:0] mag_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [VOL_W-1:0]    vol_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [WIDE_W-1:0]   wide_t;
  typedef logic [SUM_W-1:0]    sum_t;

  localparam vol_t   VOL_MAX      = 7'd100;
  localparam prod_t  PCT_SCALE    = 22'd100;
  localparam mag_t   FULL_SCALE   = 16'd32767;
  localparam int     FS_SHIFT     = 15;       // FULL_SCALE = 2^15 - 1
  localparam int     DECAY_SHIFT  = 3;        // divide by 8

  // floor(x/100) = (x * ceil(2^29/100)) >> 29, exact for x < 2^29/88
  localparam logic [RECIP_W-1:0] DIV100_MUL   = 23'd5368710;
  localparam int                 DIV100_SHIFT = 29;

  // floor(x/32767) for x <= 100*32768: quotient estimate from the top
  // bits, remainder stays below twice the divisor, one correction step.
  function automatic level_t div_full_scale(input prod_t x);
    level_t q0;
    mag_t   rem;
    q0  = x[PROD_W-1:FS_SHIFT];
    rem = {1'b0, x[FS_SHIFT-1:0]} + {{(SAMPLE_W-LEVEL_W){1'b0}}, q0};
    if (rem >= FULL_SCALE) begin
      div_full_scale = q0 + level_t'(1);
    end else begin
      div_full_scale = q0;
    end
  endfunction

endpackage

@@ hdl/audio_peak_level_meter.sv @@
// Channel  Dir  Ports                                Contents
// in_      in   in_tvalid/in_tready/in_tdata/in_tlast  PCM sample, tlast = last of buffer
// out_     out  out_tvalid/out_tready/out_tdata        smoothed level, one per buffer
// cfg_     in   cfg_wr_en/cfg_wr_data                  volume percent
//
// One item per clock sustained while out_ does not hold back results. A last
// item's level passes the input reg, gain product, divide by 100, peak
// scale and level stages and is registered at the output; the limit is
// the peak compare in the divide stage, one compare per cycle.
// rst_n is synchronous, active low: empties the pipeline, clears peak and
// level, sets volume to 100.
// A waiting result stalls only the level stage; non-last items keep
// flowing until a second level is ready behind the held one.
module audio_peak_level_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] sample (signed)
  input  logic        in_tlast,     // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [6:0] level, [7] zero
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data   // volume_percent
);

  // volume, saturated at write time
  apl_pkg::vol_t   vol_r;

  // stage 0: input register
  logic            s0_vld_r;
  apl_pkg::mag_t   s0_smp_r;
  logic            s0_last_r;
  // stage 1: |sample| * volume
  logic            s1_vld_r;
  apl_pkg::prod_t  s1_prod_r;
  logic            s1_last_r;
  // stage 2: scaled magnitude, peak tracking
  logic            s2_vld_r;
  apl_pkg::mag_t   s2_mag_r;
  logic            s2_last_r;
  // stage 3: peak * 100, last items only
  logic            s3_vld_r;
  apl_pkg::prod_t  s3_pk100_r;
  // result
  logic            out_vld_r;
  apl_pkg::level_t out_lvl_r;

  apl_pkg::mag_t   peak_r;
  apl_pkg::level_t level_r;

  logic            out_free, s3_free, s2_free, s1_free, s0_free;
  logic            mv3, mv2, mv1, mv0, in_acc;

  apl_pkg::mag_t   abs_nxt;
  apl_pkg::prod_t  prod_nxt;
  apl_pkg::wide_t  recip_prod;
  apl_pkg::mag_t   mag_nxt;
  apl_pkg::mag_t   peak_max;
  apl_pkg::prod_t  pk100_nxt;
  apl_pkg::level_t fresh;
  apl_pkg::sum_t   decay_sum;
  apl_pkg::level_t level_nxt;

  // Flow control: a stage takes new data when empty or draining.
  // Non-last items end at stage 2, so only levels wait for out_tready.
  assign out_free  = !out_vld_r || out_tready;
  assign mv3       = s3_vld_r && out_free;
  assign s3_free   = !s3_vld_r || out_free;
  assign mv2       = s2_vld_r && (!s2_last_r || s3_free);
  assign s2_free   = !s2_vld_r || mv2;
  assign mv1       = s1_vld_r && s2_free;
  assign s1_free   = !s1_vld_r || s2_free;
  assign mv0       = s0_vld_r && s1_free;
  assign s0_free   = !s0_vld_r || s1_free;
  assign in_tready = s0_free;
  assign in_acc    = in_tvalid && s0_free;

  // Datapath
  always_comb begin
    // two's complement magnitude; -32768 gives 32768 unsigned
    abs_nxt    = s0_smp_r[15] ? (~s0_smp_r + apl_pkg::mag_t'(1)) : s0_smp_r;
    prod_nxt   = {{(apl_pkg::PROD_W - apl_pkg::SAMPLE_W){1'b0}}, abs_nxt}
               * {{(apl_pkg::PROD_W - apl_pkg::VOL_W){1'b0}}, vol_r};
    recip_prod = {{apl_pkg::RECIP_W{1'b0}}, s1_prod_r}
               * {{apl_pkg::PROD_W{1'b0}}, apl_pkg::DIV100_MUL};
    mag_nxt    = recip_prod[apl_pkg::DIV100_SHIFT +: apl_pkg::SAMPLE_W];
    peak_max   = (s2_mag_r > peak_r) ? s2_mag_r : peak_r;
    pk100_nxt  = {{(apl_pkg::PROD_W - apl_pkg::SAMPLE_W){1'b0}}, peak_max}
               * apl_pkg::PCT_SCALE;
    fresh      = apl_pkg::div_full_scale(s3_pk100_r);
    // old*7 + new = (old << 3) - old + new
    decay_sum  = ({{(apl_pkg::SUM_W - apl_pkg::LEVEL_W){1'b0}}, level_r}
                  << apl_pkg::DECAY_SHIFT)
               - {{(apl_pkg::SUM_W - apl_pkg::LEVEL_W){1'b0}}, level_r}
               + {{(apl_pkg::SUM_W - apl_pkg::LEVEL_W){1'b0}}, fresh};
    if (fresh > level_r) begin
      level_nxt = fresh;                     // fast attack
    end else begin
      level_nxt = decay_sum[apl_pkg::DECAY_SHIFT +: apl_pkg::LEVEL_W];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r     <= apl_pkg::VOL_MAX;
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      peak_r    <= '0;
      level_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        vol_r <= (cfg_wr_data > apl_pkg::VOL_MAX) ? apl_pkg::VOL_MAX : cfg_wr_data;
      end
      if (s0_free) begin
        s0_vld_r <= in_tvalid;
      end
      if (s1_free) begin
        s1_vld_r <= s0_vld_r;
      end
      if (s2_free) begin
        s2_vld_r <= s1_vld_r;
      end
      if (s3_free) begin
        s3_vld_r <= mv2 && s2_last_r;
      end
      if (out_free) begin
        out_vld_r <= s3_vld_r;
      end
      if (mv2) begin
        peak_r <= s2_last_r ? '0 : peak_max;
      end
      if (mv3) begin
        level_r <= level_nxt;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_smp_r  <= in_tdata;
      s0_last_r <= in_tlast;
    end
    if (mv0) begin
      s1_prod_r <= prod_nxt;
      s1_last_r <= s0_last_r;
    end
    if (mv1) begin
      s2_mag_r  <= mag_nxt;
      s2_last_r <= s1_last_r;
    end
    if (mv2 && s2_last_r) begin
      s3_pk100_r <= pk100_nxt;
    end
    if (mv3) begin
      out_lvl_r <= level_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_lvl_r};

  // Checks
  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    vol_r <= apl_pkg::VOL_MAX)
    else $error("volume above 100");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= apl_pkg::VOL_MAX)
    else $error("stored level above 100");

  a_peak_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mv2 && s2_last_r) |=> (peak_r == '0))
    else $error("peak not cleared after buffer end");

  a_out_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
    mv3 |=> (out_vld_r && (out_lvl_r == level_r)))
    else $error("emitted level differs from stored level");

endmodule
